/* src/assert_macros.svh */
// Assertion helpers used by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pli_pkg.sv */
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Field widths, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

    // Widths of the item fields.
    localparam int WL_W   = 16;
    localparam int VAL_W  = 24;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;
    localparam int FRAC_W = 16;

    // Width of one table word: wavelength above value.
    localparam int ENTRY_W = WL_W + VAL_W;

    // Product of a value difference and a fraction.
    localparam int PROD_W = (VAL_W + 1) + (FRAC_W + 1);

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_SUM
    } t_state;

endpackage

`default_nettype wire

/* src/pli_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/piecewise_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table in RAM, sequential segment search, restoring divider
// for the segment fraction and one multiply to blend the two values.
//
// Channel   Direction  Handshake                  Word
// item      in         start & !busy              operation, index, wavelength, value
// result    out        o_result_valid (1 cycle)   result_value, in_range
// config    in         i_cfg_valid & o_cfg_ready  point_count
//
// A load is written into the table at its accept edge and leaves the block idle.
// A sample reads the last entry, then scans the table entries in index order
// over the RAM read port, runs the restoring divider, the multiply and the sum,
// and registers the result word. Out-of-range queries finish at the first
// scan step, on entry 0.
// Reset clears the sequencer and sets point_count to 1; the table is not
// cleared. The result receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_operation,
    input  wire logic [pli_pkg::IDX_W-1:0]       i_entry_index,
    input  wire logic [pli_pkg::WL_W-1:0]        i_wavelength,
    input  wire logic signed [pli_pkg::VAL_W-1:0] i_point_value,
    output logic                                 o_result_valid,
    output logic signed [pli_pkg::VAL_W-1:0]     o_result_value,
    output logic                                 o_in_range,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pli_pkg::CNT_W-1:0]       i_cfg_point_count
);

    import pli_pkg::*;

`include "assert_macros.svh"

    localparam int AW = $clog2(MAX_POINTS);

    // Control registers.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_point_count;
    logic               r_res_valid, n_res_valid;

    // Datapath registers.
    logic [WL_W-1:0]          r_q, n_q;
    logic [CNT_W-1:0]         r_n, n_n;
    logic [CNT_W-1:0]         r_k, n_k;
    logic [WL_W-1:0]          r_last_wl, n_last_wl;
    logic [VAL_W-1:0]         r_last_val, n_last_val;
    logic [WL_W-1:0]          r_prev_wl, n_prev_wl;
    logic [VAL_W-1:0]         r_prev_val, n_prev_val;
    logic signed [VAL_W:0]    r_diff, n_diff;
    logic [VAL_W-1:0]         r_vl, n_vl;
    logic [WL_W-1:0]          r_den, n_den;
    logic [WL_W-1:0]          r_rem, n_rem;
    logic [FRAC_W-1:0]        r_quot, n_quot;
    logic [3:0]               r_bit, n_bit;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [VAL_W-1:0]         r_res_value, n_res_value;
    logic                     r_in_range, n_in_range;

    // Table RAM signals.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [WL_W-1:0]      rd_wl;
    logic [VAL_W-1:0]     rd_val;

    logic                 accept;
    logic [CNT_W-1:0]     n_active;
    logic [WL_W:0]        rem_shift;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = !busy;
    assign accept      = start && !busy;

    // Breakpoints in use: zero acts as one, large counts saturate.
    always_comb begin
        if (r_point_count == '0) begin
            n_active = CNT_W'(1);
        end else if (int'(r_point_count) > MAX_POINTS) begin
            n_active = CNT_W'(MAX_POINTS);
        end else begin
            n_active = r_point_count;
        end
    end

    // Loads write the table at their accept edge; indexes past the table drop.
    assign ram_we    = accept && (i_operation == OP_LOAD)
                       && (int'(i_entry_index) < MAX_POINTS);
    assign ram_waddr = AW'(i_entry_index);
    assign ram_wdata = {i_wavelength, i_point_value};

    assign rd_wl  = ram_rdata[ENTRY_W-1:VAL_W];
    assign rd_val = ram_rdata[VAL_W-1:0];

    // Read address: last entry on accept, then entry 0, then one ahead of the scan.
    always_comb begin
        unique case (r_state)
            ST_IDLE: ram_raddr = AW'(n_active - CNT_W'(1));
            ST_SCAN: ram_raddr = AW'(r_k + CNT_W'(1));
            default: ram_raddr = '0;
        endcase
    end

    pli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rem_shift = {r_rem, 1'b0};

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_res_valid = 1'b0;
        n_q         = r_q;
        n_n         = r_n;
        n_k         = r_k;
        n_last_wl   = r_last_wl;
        n_last_val  = r_last_val;
        n_prev_wl   = r_prev_wl;
        n_prev_val  = r_prev_val;
        n_diff      = r_diff;
        n_vl        = r_vl;
        n_den       = r_den;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_bit       = r_bit;
        n_prod      = r_prod;
        n_res_value = r_res_value;
        n_in_range  = r_in_range;

        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_operation == OP_SAMPLE)) begin
                    n_q     = i_wavelength;
                    n_n     = n_active;
                    n_state = ST_LAST;
                end
            end

            // The last breakpoint arrives; entry 0 is being read.
            ST_LAST: begin
                n_last_wl  = rd_wl;
                n_last_val = rd_val;
                n_k        = '0;
                n_state    = ST_SCAN;
            end

            // One table entry arrives per cycle, in index order.
            ST_SCAN: begin
                n_prev_wl  = rd_wl;
                n_prev_val = rd_val;
                n_k        = r_k + CNT_W'(1);
                if (r_k == '0) begin
                    if ((r_q < rd_wl) || (r_q > r_last_wl)) begin
                        n_res_value = '0;
                        n_in_range  = 1'b0;
                        n_res_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end else if (r_n == CNT_W'(1)) begin
                        n_res_value = r_last_val;
                        n_in_range  = 1'b1;
                        n_res_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else if ((r_prev_wl <= r_q) && (r_q < rd_wl)) begin
                    // Segment found: set up the fraction division.
                    n_den   = rd_wl - r_prev_wl;
                    n_rem   = r_q - r_prev_wl;
                    n_quot  = '0;
                    n_bit   = 4'd15;
                    n_vl    = r_prev_val;
                    n_diff  = $signed({rd_val[VAL_W-1], rd_val})
                              - $signed({r_prev_val[VAL_W-1], r_prev_val});
                    n_state = ST_DIV;
                end else if (r_k == r_n - CNT_W'(1)) begin
                    // No segment matched: the result is the last breakpoint's value.
                    n_res_value = r_last_val;
                    n_in_range  = 1'b1;
                    n_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            // Restoring division, one quotient bit per cycle.
            ST_DIV: begin
                if (rem_shift >= {1'b0, r_den}) begin
                    n_rem  = WL_W'(rem_shift - {1'b0, r_den});
                    n_quot = {r_quot[FRAC_W-2:0], 1'b1};
                end else begin
                    n_rem  = rem_shift[WL_W-1:0];
                    n_quot = {r_quot[FRAC_W-2:0], 1'b0};
                end
                n_bit = r_bit - 4'd1;
                if (r_bit == '0) begin
                    n_state = ST_MUL;
                end
            end

            ST_MUL: begin
                n_prod  = r_diff * $signed({1'b0, r_quot});
                n_state = ST_SUM;
            end

            // Arithmetic shift by the fraction width, then add the left value.
            ST_SUM: begin
                n_res_value = r_vl + r_prod[FRAC_W+VAL_W-1:FRAC_W];
                n_in_range  = 1'b1;
                n_res_valid = 1'b1;
                n_state     = ST_IDLE;
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_res_valid   <= 1'b0;
            r_point_count <= CNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_point_count <= i_cfg_point_count;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_q         <= n_q;
        r_n         <= n_n;
        r_k         <= n_k;
        r_last_wl   <= n_last_wl;
        r_last_val  <= n_last_val;
        r_prev_wl   <= n_prev_wl;
        r_prev_val  <= n_prev_val;
        r_diff      <= n_diff;
        r_vl        <= n_vl;
        r_den       <= n_den;
        r_rem       <= n_rem;
        r_quot      <= n_quot;
        r_bit       <= n_bit;
        r_prod      <= n_prod;
        r_res_value <= n_res_value;
        r_in_range  <= n_in_range;
    end

    assign o_result_valid = r_res_valid;
    assign o_result_value = $signed(r_res_value);
    assign o_in_range     = r_in_range;

    // A result appears only as the sequencer returns to idle.
    `PLI_ASSERT_IMPL(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !busy,
        "result word while the sequencer is busy")

    // An out-of-range result carries a zero value.
    `PLI_ASSERT_IMPL(a_out_of_range_zero, i_clk, i_rst_n,
        o_result_valid && !o_in_range, o_result_value == '0,
        "out-of-range result with a nonzero value")

    // A load completes at once and gives no result.
    `PLI_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n,
        start && !busy && (i_operation == OP_LOAD), !busy && !o_result_valid,
        "load word produced a result or left the block busy")

    // An accepted sample starts the search.
    `PLI_ASSERT_NEXT(a_sample_starts, i_clk, i_rst_n,
        start && !busy && (i_operation == OP_SAMPLE), r_state == ST_LAST,
        "sample word did not start the table search")

endmodule

`default_nettype wire

/* dv/tb_piecewise_linear_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear interpolator testbench
// Loads breakpoint tables of many sizes and shapes; samples hit breakpoints,
// the ends and just past them. Each sample result is checked against a predictor
// that runs on the command words as the block accepts them. The run covers
// several point counts, including zero and counts past the table depth.
// ----------------------------------------------------------------------------

module tb_piecewise_linear_interpolator;

    import pli_pkg::*;

    localparam int TABLE_DEPTH       = 64;
    localparam int RESET_CYCLES      = 9;
    localparam int IDLE_PCT          = 11;
    localparam int RANDOM_WORDS      = 650;
    localparam int SETTLE_CYCLES     = 90;
    localparam int RESULT_WAIT_LIMIT = 5000;

    // One command word as presented on the item ports.
    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        index;
        logic [WL_W-1:0]         wl;
        logic signed [VAL_W-1:0] value;
    } t_table_cmd;

    // One result word of a sample.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    in_range;
    } t_lookup;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    logic o_result_valid;
    logic signed [VAL_W-1:0] o_result_value;
    logic o_in_range;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_point_count = '0;

    t_table_cmd cur_cmd = '0;
    t_table_cmd cmd_queue [$];
    t_lookup    predicted_lookups [$];
    t_lookup    oldest_lookup;

    // Predictor state, updated only on accepted words.
    logic [WL_W-1:0]         wl_table  [TABLE_DEPTH];
    logic signed [VAL_W-1:0] val_table [TABLE_DEPTH];
    logic [CNT_W-1:0]        model_point_count = 7'd1;

    // Generator view of the table, used to aim queries.
    logic [WL_W-1:0] plan_wl [TABLE_DEPTH];

    int  items_issued   = 0;
    int  items_accepted = 0;
    int  failures       = 0;
    bit  steady_stretch = 1'b0;

    piecewise_linear_interpolator #(
        .MAX_POINTS(TABLE_DEPTH)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (cur_cmd.op),
        .i_entry_index    (cur_cmd.index),
        .i_wavelength     (cur_cmd.wl),
        .i_point_value    (cur_cmd.value),
        .o_result_valid   (o_result_valid),
        .o_result_value   (o_result_value),
        .o_in_range       (o_in_range),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_point_count(i_cfg_point_count)
    );

    always #1 i_clk = ~i_clk;

    // A count of zero behaves as one; counts past the depth saturate.
    function automatic int active_points(input logic [CNT_W-1:0] cnt);
        if (cnt == 0) return 1;
        if (cnt > TABLE_DEPTH) return TABLE_DEPTH;
        return int'(cnt);
    endfunction

    // Expected result of a sample at query q against the current table.
    function automatic t_lookup predict_lookup(input logic [WL_W-1:0] q);
        t_lookup r;
        int      n;
        longint  span, frac, lo_v, hi_v, sum;
        n = active_points(model_point_count);
        r = '0;
        if (q < wl_table[0] || q > wl_table[n-1]) return r;
        // With no matching segment the last value stands.
        r.in_range = 1'b1;
        r.value    = val_table[n-1];
        for (int i = 0; i + 1 < n; i++) begin
            if (wl_table[i] <= q && q < wl_table[i+1]) begin
                span  = longint'(wl_table[i+1]) - longint'(wl_table[i]);
                frac  = ((longint'(q) - longint'(wl_table[i])) << 16) / span;
                lo_v  = longint'(val_table[i]);
                hi_v  = longint'(val_table[i+1]);
                sum   = lo_v + (((hi_v - lo_v) * frac) >>> 16);
                r.value = sum[VAL_W-1:0];
                return r;
            end
        end
        return r;
    endfunction

    // Apply one accepted command word to the predictor.
    function automatic void apply_cmd(input t_table_cmd c);
        if (c.op == OP_LOAD) begin
            wl_table[c.index]  = c.wl;
            val_table[c.index] = c.value;
        end else begin
            predicted_lookups.push_back(predict_lookup(c.wl));
        end
        items_accepted++;
    endfunction

    task automatic push_cmd(input t_op op, input int idx, input int wl, input int val);
        t_table_cmd c;
        c.op    = op;
        c.index = idx[IDX_W-1:0];
        c.wl    = wl[WL_W-1:0];
        c.value = val[VAL_W-1:0];
        if (op == OP_LOAD) plan_wl[c.index] = c.wl;
        cmd_queue.push_back(c);
        items_issued++;
    endtask

    // Load entries 0 to n-1: mostly ascending tables, some with repeated
    // positions, some spanning the whole wavelength range, some unordered.
    task automatic build_table(input int n);
        int style, base_wl, room, w, step;
        style   = $urandom_range(0, 9);
        base_wl = (style == 1) ? 0 : $urandom_range(0, 4096);
        room    = 65535 - base_wl;
        w       = base_wl;
        for (int i = 0; i < n; i++) begin
            if (style == 0) begin
                w = $urandom_range(0, 65535);
            end else if (i > 0) begin
                step = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 2 * room / n);
                w    = (w + step > 65535) ? 65535 : w + step;
            end
            if (style == 1 && i == n - 1) w = 65535;
            push_cmd(OP_LOAD, i, w, $urandom());
        end
    endtask

    // One random word for a table of n points: mostly aimed samples, with
    // stray loads mixed in that may break the ordering of the table.
    task automatic push_random_word(input int n);
        int pick, lo, hi, q;
        lo   = int'(plan_wl[0]);
        hi   = int'(plan_wl[n-1]);
        pick = $urandom_range(0, 99);
        if (pick < 40)      q = $urandom_range(lo, hi);
        else if (pick < 55) q = int'(plan_wl[$urandom_range(0, n - 1)]);
        else if (pick < 65) q = pick[0] ? lo : hi;
        else if (pick < 75) q = pick[0] ? lo - 1 : hi + 1;
        else if (pick < 90) q = $urandom_range(0, 65535);
        else begin
            push_cmd(OP_LOAD, $urandom_range(0, 63), $urandom(), $urandom());
            return;
        end
        push_cmd(OP_SAMPLE, $urandom_range(0, 63), q, $urandom());
    endtask

    // Wait until every word is accepted and every result is in, then let the
    // block run out before anything else happens.
    task automatic settle_block();
        int waited;
        waited = 0;
        do @(posedge i_clk); while (items_accepted != items_issued || start);
        while (predicted_lookups.size() != 0 && waited < RESULT_WAIT_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (predicted_lookups.size() != 0) begin
            $error("%0d sample results never arrived", predicted_lookups.size());
            failures++;
            predicted_lookups.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_point_count(input logic [CNT_W-1:0] cnt);
        repeat ($urandom_range(0, 3)) @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_point_count <= cnt;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_point_count = cnt;
        i_cfg_valid <= 1'b0;
    endtask

    // Driver: presents the next command word whenever the slot is free,
    // holding off at random outside the steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_cmd(cur_cmd);
            end
            if (!start || !busy) begin
                if (cmd_queue.size() != 0 &&
                    (steady_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_cmd <= cmd_queue.pop_front();
                    start   <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result strobe is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (predicted_lookups.size() == 0) begin
                $error("result word with no sample pending: value %0d, in_range %0b",
                       o_result_value, o_in_range);
                failures++;
            end else begin
                oldest_lookup = predicted_lookups.pop_front();
                if (o_result_value !== oldest_lookup.value) begin
                    $error("result_value: expected %0d, got %0d",
                           oldest_lookup.value, o_result_value);
                    failures++;
                end
                if (o_in_range !== oldest_lookup.in_range) begin
                    $error("in_range: expected %0b, got %0b",
                           oldest_lookup.in_range, o_in_range);
                    failures++;
                end
            end
        end
    end

    // Stimulus and phase sequencing.
    initial begin
        int phase, n, first_random;
        logic [CNT_W-1:0] cnt;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single breakpoint at the reset count: exact hit, just below, just above.
        push_cmd(OP_LOAD, 0, 16'h1000, 24'h7FFFFF);
        push_cmd(OP_SAMPLE, 63, 16'h1000, 24'h000000);
        push_cmd(OP_SAMPLE, 0, 16'h0FFF, 24'hFFFFFF);
        push_cmd(OP_SAMPLE, 21, 16'h1001, 24'h555555);
        settle_block();

        // Five points: full value swing, a repeated position, a step back,
        // and the last point at the top of the wavelength range.
        set_point_count(7'd5);
        push_cmd(OP_LOAD, 0, 16'h0000, 24'h800000);
        push_cmd(OP_LOAD, 1, 16'h8000, 24'h7FFFFF);
        push_cmd(OP_LOAD, 2, 16'h8000, 24'h000000);
        push_cmd(OP_LOAD, 3, 16'h4000, 24'h123456);
        push_cmd(OP_LOAD, 4, 16'hFFFF, 24'h800000);
        push_cmd(OP_LOAD, 63, 16'hFFFF, 24'hFFFFFF);
        push_cmd(OP_SAMPLE, 0, 16'h0000, 24'h000000);
        push_cmd(OP_SAMPLE, 42, 16'h7FFF, 24'hAAAAAA);
        push_cmd(OP_SAMPLE, 0, 16'h4000, 24'h000000);
        push_cmd(OP_SAMPLE, 0, 16'h8000, 24'h000000);
        push_cmd(OP_SAMPLE, 0, 16'hC000, 24'h000000);
        push_cmd(OP_SAMPLE, 0, 16'hFFFF, 24'h000000);

        // Random phases: a fresh table for each point count, then samples.
        first_random = items_issued;
        phase = 0;
        while (items_issued - first_random < RANDOM_WORDS) begin
            settle_block();
            case (phase)
                0: cnt = 7'd0;
                1: cnt = 7'd2;
                2: cnt = 7'd127;
                3: cnt = 7'd65;
                4: cnt = 7'd64;
                5: cnt = 7'd1;
                default: cnt = ($urandom_range(0, 4) == 0)
                               ? CNT_W'($urandom_range(13, 64))
                               : CNT_W'($urandom_range(2, 12));
            endcase
            steady_stretch = (phase == 3 || phase == 4);
            set_point_count(cnt);
            n = active_points(cnt);
            build_table(n);
            repeat ($urandom_range(25, 45)) push_random_word(n);
            phase++;
        end

        settle_block();
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
